FILE: src/brs_pkg.sv
// Shared types and fixed field widths for the block range add / range sum unit.
package brs_pkg;

    localparam int IDX_W = 11;
    localparam int AMT_W = 32;
    localparam int SUM_W = 64;
    localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_POINT_ADD = 2'd0,
        OP_RANGE_ADD = 2'd1,
        OP_RANGE_SUM = 2'd2
    } op_t;

    typedef struct packed {
        logic             go;
        logic             reject;
        op_t              op;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
        logic [AMT_W-1:0] amount;
    } cmd_t;

    typedef struct packed {
        logic             done;
        logic             status;
        logic [SUM_W-1:0] range_sum;
    } res_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] tag;
    } blk_entry_t;

endpackage

FILE: src/brs_locate.sv
// Block number of two element positions by reciprocal multiplication.
module brs_locate #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int BLOCK_LEN = 32,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN,
    localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1
) (
    input  logic          clk,
    input  logic [AW-1:0] lo_pos,
    input  logic [AW-1:0] hi_pos,
    output logic [BW-1:0] lo_blk,
    output logic [BW-1:0] hi_blk
);

    // With 2^LB >= BLOCK_LEN the rounded-up reciprocal is exact for every AW-bit position.
    localparam int LB = $clog2(BLOCK_LEN);
    localparam int SH = AW + LB;
    localparam int MW = AW + 2;
    localparam int PW = AW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);

    logic [PW-1:0] lo_prod;
    logic [PW-1:0] hi_prod;
    logic [BW-1:0] lo_blk_reg;
    logic [BW-1:0] hi_blk_reg;

    assign lo_prod = PW'(lo_pos) * PW'(RECIP);
    assign hi_prod = PW'(hi_pos) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        lo_blk_reg <= BW'(lo_prod >> SH);
        hi_blk_reg <= BW'(hi_prod >> SH);
    end

    assign lo_blk = lo_blk_reg;
    assign hi_blk = hi_blk_reg;

endmodule

FILE: src/brs_core.sv
// Sequencer with the element memory and the block sum/tag memory.
module brs_core #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int BLOCK_LEN = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  brs_pkg::cmd_t cmd,
    output logic          busy,
    output brs_pkg::res_t res
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int NW = $clog2(BLOCK_LEN + 1);
    localparam int XW = AW + 9;
    localparam logic [AW-1:0] LAST_POS = AW'(MAX_ELEMENTS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_BOUND,
        ST_SETUP,
        ST_STREAM,
        ST_BLK_RD,
        ST_BLK_MUL,
        ST_BLK_WR,
        ST_MID
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             clr_ptr_reg, clr_ptr_next;
    brs_pkg::op_t              op_reg, op_next;
    logic                      reject_reg, reject_next;
    logic [AW-1:0]             lo_pos_reg, lo_pos_next;
    logic [AW-1:0]             hi_pos_reg, hi_pos_next;
    logic [63:0]               amt_reg, amt_next;
    logic [63:0]               acc_reg, acc_next;
    logic [AW-1:0]             bnd1_reg, bnd1_next;
    logic [AW-1:0]             bnd2_reg, bnd2_next;
    logic [63:0]               mid_inc_reg, mid_inc_next;
    logic                      two_seg_reg, two_seg_next;
    logic                      seg_sel_reg, seg_sel_next;
    logic [AW-1:0]             seg_end_reg, seg_end_next;
    logic [BW-1:0]             seg_blk_reg, seg_blk_next;
    logic [NW-1:0]             seg_n_reg, seg_n_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic                      rd_on_reg, rd_on_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             pend_addr_reg, pend_addr_next;
    logic [BW-1:0]             mid_ptr_reg, mid_ptr_next;
    logic                      mid_on_reg, mid_on_next;
    logic                      mid_pend_reg, mid_pend_next;
    logic [BW-1:0]             mid_addr_reg, mid_addr_next;
    logic [63:0]               prod_reg, prod_next;
    logic                      done_reg, done_next;
    logic                      status_reg, status_next;
    logic [63:0]               sum_reg, sum_next;

    logic [BW-1:0]             lo_blk;
    logic [BW-1:0]             hi_blk;
    logic                      is_query;
    logic                      has_mid;
    logic                      clr_in_blocks;

    logic                      elem_re;
    logic [AW-1:0]             elem_raddr;
    logic                      elem_we;
    logic [AW-1:0]             elem_waddr;
    logic [63:0]               elem_wdata;
    logic [63:0]               elem_rdata_reg;
    logic [63:0]               elem_mem [MAX_ELEMENTS];

    logic                      blk_re;
    logic [BW-1:0]             blk_raddr;
    logic                      blk_we;
    logic [BW-1:0]             blk_waddr;
    brs_pkg::blk_entry_t       blk_wdata;
    brs_pkg::blk_entry_t       blk_rdata_reg;
    brs_pkg::blk_entry_t       blk_mem [BLOCK_COUNT];

    brs_locate #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .BLOCK_LEN(BLOCK_LEN)
    ) u_locate (
        .clk(clk),
        .lo_pos(lo_pos_reg),
        .hi_pos(hi_pos_reg),
        .lo_blk(lo_blk),
        .hi_blk(hi_blk)
    );

    assign is_query = (op_reg == brs_pkg::OP_RANGE_SUM);
    assign has_mid = ((BW + 1)'(hi_blk) > ((BW + 1)'(lo_blk) + (BW + 1)'(1)));
    assign clr_in_blocks = ((AW + 1)'(clr_ptr_reg) < (AW + 1)'(BLOCK_COUNT));

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        op_next        = op_reg;
        reject_next    = reject_reg;
        lo_pos_next    = lo_pos_reg;
        hi_pos_next    = hi_pos_reg;
        amt_next       = amt_reg;
        acc_next       = acc_reg;
        bnd1_next      = bnd1_reg;
        bnd2_next      = bnd2_reg;
        mid_inc_next   = mid_inc_reg;
        two_seg_next   = two_seg_reg;
        seg_sel_next   = seg_sel_reg;
        seg_end_next   = seg_end_reg;
        seg_blk_next   = seg_blk_reg;
        seg_n_next     = seg_n_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_on_next     = rd_on_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        mid_ptr_next   = mid_ptr_reg;
        mid_on_next    = mid_on_reg;
        mid_pend_next  = mid_pend_reg;
        mid_addr_next  = mid_addr_reg;
        prod_next      = prod_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        sum_next       = sum_reg;

        elem_re    = 1'b0;
        elem_raddr = rd_ptr_reg;
        elem_we    = 1'b0;
        elem_waddr = pend_addr_reg;
        elem_wdata = elem_rdata_reg + amt_reg;
        blk_re     = 1'b0;
        blk_raddr  = seg_blk_reg;
        blk_we     = 1'b0;
        blk_waddr  = seg_blk_reg;
        blk_wdata  = '{sum: blk_rdata_reg.sum + prod_reg, tag: blk_rdata_reg.tag};

        unique case (state_reg)
            ST_CLEAR:
            begin
                elem_we    = 1'b1;
                elem_waddr = clr_ptr_reg;
                elem_wdata = '0;
                blk_we     = clr_in_blocks;
                blk_waddr  = BW'(clr_ptr_reg);
                blk_wdata  = '0;
                if (clr_ptr_reg == LAST_POS)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    op_next     = cmd.op;
                    reject_next = cmd.reject;
                    lo_pos_next = AW'(cmd.first_index - 11'd1);
                    if (cmd.op == brs_pkg::OP_POINT_ADD)
                    begin
                        hi_pos_next = AW'(cmd.first_index - 11'd1);
                    end
                    else
                    begin
                        hi_pos_next = AW'(cmd.last_index - 11'd1);
                    end
                    amt_next   = {{32{cmd.amount[31]}}, cmd.amount};
                    acc_next   = '0;
                    state_next = ST_LOCATE;
                end
            end

            ST_LOCATE:
            begin
                if (reject_reg)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b1;
                    sum_next    = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BOUND;
                end
            end

            ST_BOUND:
            begin
                bnd1_next = AW'((XW'(lo_blk) + XW'(1)) * XW'(BLOCK_LEN) - XW'(1));
                bnd2_next = AW'(XW'(hi_blk) * XW'(BLOCK_LEN));
                mid_inc_next = amt_reg * 64'(BLOCK_LEN);
                two_seg_next = (lo_blk != hi_blk);
                state_next = ST_SETUP;
            end

            ST_SETUP:
            begin
                seg_end_next = two_seg_reg ? bnd1_reg : hi_pos_reg;
                seg_blk_next = lo_blk;
                seg_n_next   = NW'((AW + 1)'(seg_end_next) - (AW + 1)'(lo_pos_reg)
                                   + (AW + 1)'(1));
                seg_sel_next = 1'b0;
                rd_ptr_next  = lo_pos_reg;
                rd_on_next   = 1'b1;
                pend_next    = 1'b0;
                state_next   = ST_STREAM;
            end

            ST_STREAM:
            begin
                // Read one element ahead while the previous one is written back, or added to the sum for a query.
                if (rd_on_reg)
                begin
                    elem_re        = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == seg_end_reg)
                    begin
                        rd_on_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (is_query)
                    begin
                        acc_next = acc_reg + elem_rdata_reg;
                    end
                    else
                    begin
                        elem_we = 1'b1;
                    end
                    if (!rd_on_reg)
                    begin
                        state_next = ST_BLK_RD;
                    end
                end
            end

            ST_BLK_RD:
            begin
                blk_re     = 1'b1;
                state_next = ST_BLK_MUL;
            end

            ST_BLK_MUL:
            begin
                prod_next  = 64'((is_query ? blk_rdata_reg.tag : amt_reg) * 64'(seg_n_reg));
                state_next = ST_BLK_WR;
            end

            ST_BLK_WR:
            begin
                if (is_query)
                begin
                    acc_next = acc_reg + prod_reg;
                end
                else
                begin
                    blk_we = 1'b1;
                end
                if (two_seg_reg && !seg_sel_reg)
                begin
                    seg_sel_next = 1'b1;
                    seg_end_next = hi_pos_reg;
                    seg_blk_next = hi_blk;
                    seg_n_next   = NW'((AW + 1)'(hi_pos_reg) - (AW + 1)'(bnd2_reg)
                                       + (AW + 1)'(1));
                    rd_ptr_next  = bnd2_reg;
                    rd_on_next   = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = ST_STREAM;
                end
                else if (two_seg_reg && has_mid)
                begin
                    mid_ptr_next  = lo_blk + BW'(1);
                    mid_on_next   = 1'b1;
                    mid_pend_next = 1'b0;
                    state_next    = ST_MID;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    sum_next    = acc_next;
                    state_next  = ST_IDLE;
                end
            end

            ST_MID:
            begin
                if (mid_on_reg)
                begin
                    blk_re        = 1'b1;
                    blk_raddr     = mid_ptr_reg;
                    mid_pend_next = 1'b1;
                    mid_addr_next = mid_ptr_reg;
                    if ((mid_ptr_reg + BW'(1)) == hi_blk)
                    begin
                        mid_on_next = 1'b0;
                    end
                    else
                    begin
                        mid_ptr_next = mid_ptr_reg + BW'(1);
                    end
                end
                else
                begin
                    mid_pend_next = 1'b0;
                end
                if (mid_pend_reg)
                begin
                    blk_waddr = mid_addr_reg;
                    blk_wdata = '{sum: blk_rdata_reg.sum + mid_inc_reg,
                                  tag: blk_rdata_reg.tag + amt_reg};
                    if (is_query)
                    begin
                        acc_next = acc_reg + blk_rdata_reg.sum;
                    end
                    else
                    begin
                        blk_we = 1'b1;
                    end
                    if (!mid_on_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = 1'b0;
                        sum_next    = acc_next;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            op_reg        <= brs_pkg::OP_POINT_ADD;
            reject_reg    <= 1'b0;
            lo_pos_reg    <= '0;
            hi_pos_reg    <= '0;
            amt_reg       <= '0;
            acc_reg       <= '0;
            bnd1_reg      <= '0;
            bnd2_reg      <= '0;
            mid_inc_reg   <= '0;
            two_seg_reg   <= 1'b0;
            seg_sel_reg   <= 1'b0;
            seg_end_reg   <= '0;
            seg_blk_reg   <= '0;
            seg_n_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_on_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            mid_ptr_reg   <= '0;
            mid_on_reg    <= 1'b0;
            mid_pend_reg  <= 1'b0;
            mid_addr_reg  <= '0;
            prod_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            op_reg        <= op_next;
            reject_reg    <= reject_next;
            lo_pos_reg    <= lo_pos_next;
            hi_pos_reg    <= hi_pos_next;
            amt_reg       <= amt_next;
            acc_reg       <= acc_next;
            bnd1_reg      <= bnd1_next;
            bnd2_reg      <= bnd2_next;
            mid_inc_reg   <= mid_inc_next;
            two_seg_reg   <= two_seg_next;
            seg_sel_reg   <= seg_sel_next;
            seg_end_reg   <= seg_end_next;
            seg_blk_reg   <= seg_blk_next;
            seg_n_reg     <= seg_n_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_on_reg     <= rd_on_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            mid_ptr_reg   <= mid_ptr_next;
            mid_on_reg    <= mid_on_next;
            mid_pend_reg  <= mid_pend_next;
            mid_addr_reg  <= mid_addr_next;
            prod_reg      <= prod_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_re)
        begin
            blk_rdata_reg <= blk_mem[blk_raddr];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = '{done: done_reg, status: status_reg, range_sum: sum_reg};

endmodule

FILE: src/block_range_add_range_sum_unit.sv
// Top level of the block range add / range sum unit: register, checks and core.
//
// An array of MAX_ELEMENTS signed 64-bit elements, indexed from 1, is kept in
// blocks of BLOCK_LEN elements, each with a block sum and a pending add tag.
// A command transfer happens at a rising edge where start is high and busy is
// low; action selects point add, range add or range sum over first_index to
// last_index with amount. Every command gives exactly one result: done is high
// for one cycle with range_sum (the sum for a query, zero otherwise) and
// status (1 when the command was rejected and changed nothing). The receiver
// cannot stall; a result is taken in the cycle it is shown, and a new command
// may be given in that same cycle.
// From the transfer a command passes the locate, bound and setup states, then
// for one edge block streams over its touched elements and does a block read,
// multiply and write; if the range ends in another block, that edge block repeats
// this, and any whole blocks in between follow. The element memory port streams
// one element per cycle, and the block memory one whole block per cycle.
// A rejected command finishes in the locate state and touches neither memory.
// After reset a clearing pass over every element position zeroes both memories
// while busy is high; element_count writes through cfg_we are taken at any time.
module block_range_add_range_sum_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int BLOCK_LEN = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [10:0]        first_index,
    input  logic [10:0]        last_index,
    input  logic signed [31:0] amount,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_wdata,
    output logic               done,
    output logic signed [63:0] range_sum,
    output logic               status
);

    localparam logic [16:0] MAX_W = 17'(MAX_ELEMENTS);

    logic [10:0]   element_count_reg;
    logic [16:0]   count_raw;
    logic [16:0]   count_eff;
    logic [16:0]   first_w;
    logic [16:0]   last_w;
    brs_pkg::op_t  op;
    logic          op_known;
    logic          bad_index;
    brs_pkg::cmd_t cmd;
    brs_pkg::res_t res;
    logic          core_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= brs_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            element_count_reg <= cfg_wdata;
        end
    end

    // A count of zero behaves as one element, and any count beyond the array as the whole array.
    assign count_raw = 17'(element_count_reg);
    always_comb
    begin
        if (count_raw == 17'd0)
        begin
            count_eff = 17'd1;
        end
        else if (count_raw > MAX_W)
        begin
            count_eff = MAX_W;
        end
        else
        begin
            count_eff = count_raw;
        end
    end

    assign op       = brs_pkg::op_t'(action);
    assign op_known = (op == brs_pkg::OP_POINT_ADD) || (op == brs_pkg::OP_RANGE_ADD) ||
                      (op == brs_pkg::OP_RANGE_SUM);
    assign first_w  = 17'(first_index);
    assign last_w   = 17'(last_index);

    // The last index only matters for the two range operations.
    assign bad_index = (first_w == 17'd0) || (first_w > count_eff) ||
                       ((op != brs_pkg::OP_POINT_ADD) &&
                        ((last_w > count_eff) || (first_w > last_w)));

    assign cmd = '{go: start && !core_busy,
                   reject: !op_known || bad_index,
                   op: op,
                   first_index: first_index,
                   last_index: last_index,
                   amount: amount};

    brs_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .BLOCK_LEN(BLOCK_LEN)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .busy(core_busy),
        .res(res)
    );

    assign busy      = core_busy;
    assign done      = res.done;
    assign range_sum = res.range_sum;
    assign status    = res.status;

endmodule

FILE: src/brs_checker.sv
// Port-level checks for the block range add / range sum unit and their bind.
module brs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] range_sum,
    input logic        status
);

    // A rejected command never reports a sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (range_sum == 64'd0))
        else $error("rejected command reported a nonzero sum");

    // Results only come out of work that kept the unit busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    // A command transfer makes the unit busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after a command transfer");

    // No command finishes in the cycle right after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result one cycle after a command transfer");

    // Each command shows its result for one cycle only.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule

bind block_range_add_range_sum_unit brs_checker u_brs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .range_sum(range_sum),
    .status(status)
);
